// ===== src/dfr_pkg.sv =====
package dfr_pkg;

   localparam logic [7:0] SYNC_BYTE = 8'hF5;

   localparam logic [1:0] STATUS_GOOD    = 2'd0;
   localparam logic [1:0] STATUS_BAD_HDR = 2'd1;
   localparam logic [1:0] STATUS_BAD_SUM = 2'd2;

   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_LENGTH = 2'd2;
   localparam logic [1:0] PH_BODY   = 2'd3;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] status_type;

endpackage

// ===== src/dfr_if.sv =====
interface dfr_req_if;
   logic                  valid;
   logic                  ready;
   dfr_pkg::byte_type     rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dfr_rsp_if;
   logic                  valid;
   logic                  ready;
   dfr_pkg::byte_type     frame_byte;
   logic                  last_byte;
   dfr_pkg::status_type   status;
   logic                  update_request;

   modport source (output valid, output frame_byte, output last_byte, output status,
                   output update_request, input ready);
   modport sink   (input valid, input frame_byte, input last_byte, input status,
                   input update_request, output ready);
endinterface

// ===== src/dfr_store.sv =====
module dfr_store #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  dfr_pkg::byte_type        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output dfr_pkg::byte_type        rd_data
);
   import dfr_pkg::*;

   byte_type mem [DEPTH];
   byte_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/sync_length_checksum_deframer_unit.sv =====
// Results: a hunt that ends in error gives its error result in the cycle after acceptance;
// a good frame of length L starts its burst through emit_ff, the store read register and the
// output register after the checksum word, then gives one result per cycle that the sink takes.
// Throughput: one word per cycle while hunting and the output is free; after a good checksum
// word none is taken while the burst reads the frame from the store one entry a cycle as the sink takes.
// Reset: synchronous, active high; clears phase, burst state, output valid and the command code.
module sync_length_checksum_deframer_unit #(
   parameter int MAX_LEN = 16
) (
   input  logic              clock,
   input  logic              reset,
   dfr_req_if.sink           req_chan,
   dfr_rsp_if.source         rsp_chan,
   input  logic              csr_wr_en,
   input  dfr_pkg::byte_type csr_wr_data
);
   import dfr_pkg::*;

   localparam int AW = $clog2(MAX_LEN);
   localparam int LW = $clog2(MAX_LEN + 1);

   logic [1:0]    phase_ff, phase_in;
   byte_type      first_ff, first_in;
   logic [LW-1:0] len_ff, len_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   byte_type      sum_ff, sum_in;
   byte_type      cmd_ff, cmd_in;
   byte_type      code_ff, code_in;
   logic          emit_ff, emit_in;
   logic [LW-1:0] rd_cnt_ff, rd_cnt_in;
   logic          pend_ff, pend_in;
   logic          pend_last_ff, pend_last_in;
   logic          pend_first_ff, pend_first_in;
   logic          out_valid_ff, out_valid_in;
   byte_type      out_byte_ff, out_byte_in;
   logic          out_last_ff, out_last_in;
   status_type    out_status_ff, out_status_in;
   logic          out_upd_ff, out_upd_in;

   logic          out_free, accept, do_start, do_body, range_bad;
   logic          err_en, start_emit, issue, issue_last;
   status_type    err_status;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   byte_type      rx, rd_data;

   assign rx        = req_chan.rx_byte;
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !emit_ff && !pend_ff && out_free;
   assign accept    = req_chan.valid && req_chan.ready;
   assign range_bad = (rx > 8'(MAX_LEN)) || (rx < 8'd2);

   always_comb begin
      phase_in   = phase_ff;
      first_in   = first_ff;
      len_in     = len_ff;
      cnt_in     = cnt_ff;
      sum_in     = sum_ff;
      cmd_in     = cmd_ff;
      wr_en      = 1'b0;
      wr_addr    = cnt_ff;
      err_en     = 1'b0;
      err_status = STATUS_BAD_HDR;
      start_emit = 1'b0;
      do_start   = 1'b0;
      do_body    = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_FIRST: begin
               first_in = rx;
               phase_in = PH_SECOND;
            end
            PH_SECOND: begin
               if (rx == SYNC_BYTE) begin
                  phase_in = PH_LENGTH;
               end else if (first_ff == SYNC_BYTE) begin
                  do_start = 1'b1;
               end else begin
                  err_en = 1'b1;
               end
            end
            PH_LENGTH: begin
               do_start = 1'b1;
            end
            default: begin
               do_body = 1'b1;
            end
         endcase
      end
      // entry zero is always the sync byte and is never stored
      if (do_start) begin
         if (range_bad) begin
            err_en = 1'b1;
         end else begin
            wr_en   = 1'b1;
            wr_addr = AW'(1);
            len_in  = LW'(rx);
            if (rx > 8'd2) begin
               sum_in   = SYNC_BYTE + rx;
               cnt_in   = AW'(2);
               phase_in = PH_BODY;
            end else begin
               err_en     = 1'b1;
               err_status = STATUS_BAD_SUM;
            end
         end
      end
      if (do_body) begin
         wr_en = 1'b1;
         if (cnt_ff == AW'(2)) begin
            cmd_in = rx;
         end
         if ((LW'(cnt_ff) + LW'(1)) != len_ff) begin
            sum_in = sum_ff + rx;
            cnt_in = cnt_ff + AW'(1);
         end else if (sum_ff != rx) begin
            err_en     = 1'b1;
            err_status = STATUS_BAD_SUM;
         end else begin
            start_emit = 1'b1;
            phase_in   = PH_FIRST;
         end
      end
      if (err_en) begin
         phase_in = PH_FIRST;
      end
   end

   assign issue      = emit_ff && (!pend_ff || out_free);
   assign issue_last = (rd_cnt_ff + LW'(1)) == len_ff;

   always_comb begin
      emit_in       = emit_ff;
      rd_cnt_in     = rd_cnt_ff;
      pend_last_in  = pend_last_ff;
      pend_first_in = pend_first_ff;
      pend_in       = pend_ff;
      if (start_emit) begin
         emit_in   = 1'b1;
         rd_cnt_in = '0;
      end else if (issue) begin
         rd_cnt_in = rd_cnt_ff + LW'(1);
         if (issue_last) begin
            emit_in = 1'b0;
         end
      end
      if (issue) begin
         pend_in       = 1'b1;
         pend_last_in  = issue_last;
         pend_first_in = (rd_cnt_ff == '0);
      end else if (out_free) begin
         pend_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      out_upd_in    = out_upd_ff;
      if (err_en) begin
         out_valid_in  = 1'b1;
         out_byte_in   = '0;
         out_last_in   = 1'b1;
         out_status_in = err_status;
         out_upd_in    = 1'b0;
      end else if (pend_ff && out_free) begin
         out_valid_in  = 1'b1;
         out_byte_in   = pend_first_ff ? SYNC_BYTE : rd_data;
         out_last_in   = pend_last_ff;
         out_status_in = STATUS_GOOD;
         out_upd_in    = (cmd_ff == code_ff);
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign code_in = csr_wr_en ? csr_wr_data : code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         emit_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         code_ff      <= '0;
      end else begin
         phase_ff     <= phase_in;
         emit_ff      <= emit_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
         code_ff      <= code_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff      <= first_in;
      len_ff        <= len_in;
      cnt_ff        <= cnt_in;
      sum_ff        <= sum_in;
      cmd_ff        <= cmd_in;
      rd_cnt_ff     <= rd_cnt_in;
      pend_last_ff  <= pend_last_in;
      pend_first_ff <= pend_first_in;
      out_byte_ff   <= out_byte_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
      out_upd_ff    <= out_upd_in;
   end

   dfr_store #(
      .DEPTH (MAX_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (rx),
      .rd_en   (issue),
      .rd_addr (rd_cnt_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.frame_byte     = out_byte_ff;
   assign rsp_chan.last_byte      = out_last_ff;
   assign rsp_chan.status         = out_status_ff;
   assign rsp_chan.update_request = out_upd_ff;

endmodule

// ===== src/dfr_checker.sv =====
module dfr_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input dfr_pkg::byte_type   rsp_frame_byte,
   input logic                rsp_last_byte,
   input dfr_pkg::status_type rsp_status,
   input logic                rsp_update_request
);
   import dfr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_GOOD |->
         rsp_frame_byte == '0 && rsp_last_byte && !rsp_update_request)
      else $error("error word malformed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_GOOD || rsp_status == STATUS_BAD_HDR ||
                    rsp_status == STATUS_BAD_SUM)
      else $error("undefined status code");

   a_burst_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_GOOD && !rsp_last_byte |-> !req_ready)
      else $error("word taken during frame burst");

endmodule

bind sync_length_checksum_deframer_unit dfr_checker u_dfr_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_frame_byte     (rsp_chan.frame_byte),
   .rsp_last_byte      (rsp_chan.last_byte),
   .rsp_status         (rsp_chan.status),
   .rsp_update_request (rsp_chan.update_request)
);
